>>> hdl/vbh_pkg.sv
package vbh_pkg;

  // Input request as it arrives on the input channel.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [3:0]  bucket_index;
  } in_item_t;

  // Result as it leaves on the output channel.
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  hit_index;
    logic [31:0] low_bound;
    logic [31:0] high_bound;
    logic [47:0] item_count;
    logic [63:0] length_sum;
  } out_item_t;

  // Request kinds on the input channel.
  localparam logic [2:0] KIND_ADD   = 3'd0;
  localparam logic [2:0] KIND_OBS   = 3'd1;
  localparam logic [2:0] KIND_READ  = 3'd2;
  localparam logic [2:0] KIND_TOTAL = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  // Decoded operation handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_ADD,
    OP_OBS,
    OP_READ,
    OP_TOTAL,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
    logic [3:0]  bucket_index;
  } queue_item_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [1:0] ST_NO_BUCKET = 2'd3;

endpackage

>>> hdl/vbh_front.sv
module vbh_front import vbh_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        q_valid,
  output queue_item_t q_item,
  input  logic        q_pop
);

  localparam int LW = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
  localparam logic [31:0] VAL_MASK = (LW >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << LW) - 64'd1);

  queue_item_t ent_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        push;
  queue_item_t new_item;

  always_comb begin
    new_item.value        = in_data.value & VAL_MASK;
    new_item.bucket_index = in_data.bucket_index;
    case (in_data.kind)
      KIND_ADD:   new_item.op = OP_ADD;
      KIND_OBS:   new_item.op = OP_OBS;
      KIND_READ:  new_item.op = OP_READ;
      KIND_TOTAL: new_item.op = OP_TOTAL;
      KIND_CLEAR: new_item.op = OP_CLEAR;
      default:    new_item.op = OP_NOP;
    endcase
  end

  assign in_stall = (fill_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_r != 2'd0);
  assign q_item   = ent_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = (q_pop && q_valid) ? ~rptr_r : rptr_r;
    fill_nxt = fill_r;
    if (push && !(q_pop && q_valid)) begin
      fill_nxt = fill_r + 2'd1;
    end else if (!push && q_pop && q_valid) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

>>> hdl/vbh_back.sv
module vbh_back import vbh_pkg::*; #(
  parameter int BUCKETS     = 16,
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        q_valid,
  input  queue_item_t q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  localparam int LW = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
  localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int UW = $clog2(BUCKETS + 1);
  localparam logic [UW-1:0] FULL_COUNT = UW'(BUCKETS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FETCH = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  function automatic logic [47:0] sat_inc48(input logic [47:0] a);
    sat_inc48 = (a == '1) ? a : a + 48'd1;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add64 = s[64] ? '1 : s[63:0];
  endfunction

  // Tables, one write port and one registered read port each.
  logic [LW-1:0] bound_mem [BUCKETS];
  logic [47:0]   count_mem [BUCKETS];
  logic [63:0]   sum_mem   [BUCKETS];
  logic [LW-1:0] bound_q;
  logic [47:0]   count_q;
  logic [63:0]   sum_q;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic          bound_we;
  logic          cs_we;
  logic [LW-1:0] wr_bound;
  logic [47:0]   wr_count;
  logic [63:0]   wr_sum;

  state_t        state_r, state_nxt;
  logic [31:0]   max_len_r;
  logic [UW-1:0] used_r, used_nxt;
  logic [47:0]   tot_items_r, tot_items_nxt;
  logic [63:0]   tot_len_r, tot_len_nxt;
  queue_item_t   cur_r, cur_nxt;

  logic [1:0]    st_r, st_nxt;
  logic [IW-1:0] hit_r, hit_nxt;
  logic [LW-1:0] lo_r, lo_nxt;
  logic [31:0]   hi_r, hi_nxt;
  logic [47:0]   cnt_r, cnt_nxt;
  logic [63:0]   sum_r, sum_nxt;

  logic [UW-1:0] iss_r, iss_nxt;
  logic          pend_r, pend_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;
  logic          le_have_r, le_have_nxt;
  logic [IW-1:0] le_i_r, le_i_nxt;
  logic [LW-1:0] le_b_r, le_b_nxt;
  logic          min_have_r, min_have_nxt;
  logic [IW-1:0] min_i_r, min_i_nxt;
  logic [LW-1:0] min_b_r, min_b_nxt;

  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic [IW+3:0] bext;
  logic [IW+3:0] hit_ext;
  logic [LW-1:0] cur_val;
  logic          scan_done;
  logic          out_load;

  assign bext      = (IW + 4)'(q_item.bucket_index);
  assign hit_ext   = (IW + 4)'(hit_r);
  assign cur_val   = cur_r.value[LW-1:0];
  assign scan_done = !pend_r && (iss_r >= used_r);
  assign out_load  = (state_r == S_RESP) && (!out_valid_r || !out_stall);
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (bound_we) begin
      bound_mem[wr_addr] <= wr_bound;
    end
    bound_q <= bound_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cs_we) begin
      count_mem[wr_addr] <= wr_count;
      sum_mem[wr_addr]   <= wr_sum;
    end
    count_q <= count_mem[rd_addr];
    sum_q   <= sum_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    tot_items_nxt = tot_items_r;
    tot_len_nxt   = tot_len_r;
    cur_nxt       = cur_r;
    st_nxt        = st_r;
    hit_nxt       = hit_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    iss_nxt       = iss_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    le_have_nxt   = le_have_r;
    le_i_nxt      = le_i_r;
    le_b_nxt      = le_b_r;
    min_have_nxt  = min_have_r;
    min_i_nxt     = min_i_r;
    min_b_nxt     = min_b_r;
    rd_addr       = iss_r[IW-1:0];
    wr_addr       = used_r[IW-1:0];
    bound_we      = 1'b0;
    cs_we         = 1'b0;
    wr_bound      = q_item.value[LW-1:0];
    wr_count      = '0;
    wr_sum        = '0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cur_nxt      = q_item;
          st_nxt       = ST_OK;
          hit_nxt      = '0;
          lo_nxt       = '0;
          hi_nxt       = '0;
          cnt_nxt      = '0;
          sum_nxt      = '0;
          iss_nxt      = '0;
          le_have_nxt  = 1'b0;
          min_have_nxt = 1'b0;
          state_nxt    = S_RESP;
          case (q_item.op)
            OP_ADD: begin
              if (used_r == FULL_COUNT) begin
                st_nxt = ST_FULL;
              end else begin
                bound_we = 1'b1;
                cs_we    = 1'b1;
                hit_nxt  = used_r[IW-1:0];
                used_nxt = used_r + 1'b1;
              end
            end
            OP_OBS: begin
              tot_items_nxt = sat_inc48(tot_items_r);
              tot_len_nxt   = sat_add64(tot_len_r, 64'(q_item.value[LW-1:0]));
              state_nxt     = S_SCAN;
            end
            OP_READ: begin
              if (32'(q_item.bucket_index) >= 32'(used_r)) begin
                st_nxt = ST_BAD_INDEX;
              end else begin
                rd_addr   = bext[IW-1:0];
                hit_nxt   = bext[IW-1:0];
                state_nxt = S_LOAD;
              end
            end
            OP_TOTAL: begin
              cnt_nxt = tot_items_r;
              sum_nxt = tot_len_r;
            end
            OP_CLEAR: begin
              used_nxt      = '0;
              tot_items_nxt = '0;
              tot_len_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_LOAD: begin
        lo_nxt    = bound_q;
        cnt_nxt   = count_q;
        sum_nxt   = sum_q;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        // One bound is fetched per cycle; its registered data is compared in the next cycle.
        if (iss_r < used_r) begin
          rd_addr  = iss_r[IW-1:0];
          iss_nxt  = iss_r + 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = iss_r[IW-1:0];
        end
        if (pend_r) begin
          if (cur_r.op == OP_OBS) begin
            if (bound_q <= cur_val && (!le_have_r || bound_q >= le_b_r)) begin
              le_have_nxt = 1'b1;
              le_i_nxt    = pidx_r;
              le_b_nxt    = bound_q;
            end
            if (!min_have_r || bound_q <= min_b_r) begin
              min_have_nxt = 1'b1;
              min_i_nxt    = pidx_r;
              min_b_nxt    = bound_q;
            end
          end else begin
            // Upper end search: the smallest bound strictly above this one.
            if (bound_q > lo_r && (!min_have_r || bound_q < min_b_r)) begin
              min_have_nxt = 1'b1;
              min_b_nxt    = bound_q;
            end
          end
        end
        if (scan_done) begin
          if (cur_r.op == OP_OBS) begin
            if (!min_have_r || 32'(cur_val) > max_len_r) begin
              st_nxt    = ST_NO_BUCKET;
              state_nxt = S_RESP;
            end else begin
              hit_nxt   = le_have_r ? le_i_r : min_i_r;
              rd_addr   = le_have_r ? le_i_r : min_i_r;
              state_nxt = S_FETCH;
            end
          end else begin
            hi_nxt    = min_have_r ? 32'(min_b_r) - 32'd1 : max_len_r;
            state_nxt = S_RESP;
          end
        end
      end

      S_FETCH: begin
        wr_addr   = hit_r;
        cs_we     = 1'b1;
        wr_count  = sat_inc48(count_q);
        wr_sum    = sat_add64(sum_q, 64'(cur_val));
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.status     = st_r;
      out_data_nxt.hit_index  = hit_ext[3:0];
      out_data_nxt.low_bound  = 32'(lo_r);
      out_data_nxt.high_bound = hi_r;
      out_data_nxt.item_count = cnt_r;
      out_data_nxt.length_sum = sum_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    st_r       <= st_nxt;
    hit_r      <= hit_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    cnt_r      <= cnt_nxt;
    sum_r      <= sum_nxt;
    iss_r      <= iss_nxt;
    pidx_r     <= pidx_nxt;
    le_i_r     <= le_i_nxt;
    le_b_r     <= le_b_nxt;
    min_i_r    <= min_i_nxt;
    min_b_r    <= min_b_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_len_r   <= 32'hFFFF_FFFF;
      used_r      <= '0;
      tot_items_r <= '0;
      tot_len_r   <= '0;
      pend_r      <= 1'b0;
      le_have_r   <= 1'b0;
      min_have_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      used_r      <= used_nxt;
      tot_items_r <= tot_items_nxt;
      tot_len_r   <= tot_len_nxt;
      pend_r      <= pend_nxt;
      le_have_r   <= le_have_nxt;
      min_have_r  <= min_have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/variable_bucket_histogram.sv
// Histogram with software-defined bucket lower bounds. Requests are decoded by a
// front end into a two-entry queue and carried out one at a time by a back end
// that keeps the bound, count and length-sum tables in memories with one write
// port and one registered read port each. Adding a bound, reading the totals,
// clearing and unknown kinds go straight to the response state. An observation
// and a read of a bucket in use first scan the N buckets in use, one entry per
// cycle through the registered read port of the bound memory. A stalled output
// holds a new result in the response state while the previous one still waits.
// The input side keeps accepting requests into the queue while the back end
// works, until the queue is full, and a finished result waits in an output
// register while the next request is taken. All counters saturate. max_length
// may only be written while the block is idle.
module variable_bucket_histogram import vbh_pkg::*; #(
  parameter int BUCKETS     = 16,
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic        q_valid;
  queue_item_t q_item;
  logic        q_pop;

  vbh_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  vbh_back #(
    .BUCKETS     (BUCKETS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

>>> verif/variable_bucket_histogram_tb.sv
`timescale 1ns / 1ps

module variable_bucket_histogram_tb import vbh_pkg::*; ();

  localparam int TABLE_DEPTH = 16;

  // Keeps its own copy of the histogram state and works out the result that
  // each accepted request must produce.
  class bucket_tracker;
    logic [31:0] bound_q [TABLE_DEPTH];
    logic [47:0] count_q [TABLE_DEPTH];
    logic [63:0] sums_q [TABLE_DEPTH];
    int unsigned used;
    logic [47:0] total_items;
    logic [63:0] total_len;
    logic [31:0] max_len;
    out_item_t pending_results [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned full_seen;
    int unsigned no_bucket_seen;

    function new();
      max_len = '1;
      errors = 0;
      checked = 0;
      full_seen = 0;
      no_bucket_seen = 0;
      clear_all();
    endfunction

    function void clear_all();
      int i;
      for (i = 0; i < TABLE_DEPTH; i++) begin
        bound_q[i] = '0;
        count_q[i] = '0;
        sums_q[i] = '0;
      end
      used = 0;
      total_items = '0;
      total_len = '0;
    endfunction

    function logic [47:0] inc_sat(logic [47:0] a);
      return (a == '1) ? a : a + 48'd1;
    endfunction

    function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    function void take_request(in_item_t req);
      out_item_t res;
      int i;
      int le_i;
      int min_i;
      int idx;
      bit found;
      logic [31:0] best;
      res = '0;
      case (req.kind)
        KIND_ADD: begin
          if (used >= TABLE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            bound_q[used] = req.value;
            count_q[used] = '0;
            sums_q[used] = '0;
            res.hit_index = used[3:0];
            used++;
          end
        end
        KIND_OBS: begin
          total_items = inc_sat(total_items);
          total_len = add_sat(total_len, {32'd0, req.value});
          le_i = -1;
          min_i = -1;
          // Ties go to the bucket added last, both for the covering bound and
          // for the lowest bound.
          for (i = 0; i < used; i++) begin
            if (bound_q[i] <= req.value && (le_i < 0 || bound_q[i] >= bound_q[le_i]))
              le_i = i;
            if (min_i < 0 || bound_q[i] <= bound_q[min_i])
              min_i = i;
          end
          if (min_i < 0 || req.value > max_len) begin
            res.status = ST_NO_BUCKET;
          end else begin
            idx = (le_i >= 0) ? le_i : min_i;
            count_q[idx] = inc_sat(count_q[idx]);
            sums_q[idx] = add_sat(sums_q[idx], {32'd0, req.value});
            res.hit_index = idx[3:0];
          end
        end
        KIND_READ: begin
          idx = int'(req.bucket_index);
          if (idx >= used) begin
            res.status = ST_BAD_INDEX;
          end else begin
            found = 1'b0;
            best = '0;
            for (i = 0; i < used; i++) begin
              if (bound_q[i] > bound_q[idx] && (!found || bound_q[i] < best)) begin
                best = bound_q[i];
                found = 1'b1;
              end
            end
            res.hit_index = req.bucket_index;
            res.low_bound = bound_q[idx];
            res.high_bound = found ? best - 32'd1 : max_len;
            res.item_count = count_q[idx];
            res.length_sum = sums_q[idx];
          end
        end
        KIND_TOTAL: begin
          res.item_count = total_items;
          res.length_sum = total_len;
        end
        KIND_CLEAR: clear_all();
        default: ;
      endcase
      if (res.status == ST_FULL) full_seen++;
      if (res.status == ST_NO_BUCKET) no_bucket_seen++;
      pending_results.push_back(res);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      if (errors < 30)
        $display("mismatch on %s at result %0d: got %h, expected %h",
                 what, checked, got, want);
      errors++;
    endtask

    task compare_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report("result with no request waiting", 64'(got.hit_index), '0);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.status !== want.status)
        report("status", 64'(got.status), 64'(want.status));
      if (got.hit_index !== want.hit_index)
        report("hit_index", 64'(got.hit_index), 64'(want.hit_index));
      if (got.low_bound !== want.low_bound)
        report("low_bound", 64'(got.low_bound), 64'(want.low_bound));
      if (got.high_bound !== want.high_bound)
        report("high_bound", 64'(got.high_bound), 64'(want.high_bound));
      if (got.item_count !== want.item_count)
        report("item_count", 64'(got.item_count), 64'(want.item_count));
      if (got.length_sum !== want.length_sum)
        report("length_sum", got.length_sum, want.length_sum);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  bucket_tracker tracker = new();
  bit quiet = 1'b0;
  bit hold_off_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cfg_writes = 0;

  always #1 clk = ~clk;

  variable_bucket_histogram i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_item(logic [2:0] kind, logic [31:0] value,
                                         logic [3:0] idx);
    in_item_t req;
    req.kind = kind;
    req.value = value;
    req.bucket_index = idx;
    return req;
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input in_item_t req);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_request(req);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.max_len = v;
    cfg_writes++;
  endtask

  task automatic run_phase(input int unsigned phase);
    logic [31:0] scale;
    logic [31:0] v;
    in_item_t req;
    int unsigned nb;
    int unsigned r;
    int unsigned sub;
    case ($urandom_range(0, 2))
      0: scale = 32'h0000_00FF;
      1: scale = 32'h000F_FFFF;
      default: scale = '1;
    endcase
    settle();
    case (phase % 5)
      0: v = '1;
      1: v = '0;
      2: v = $urandom;
      3: v = $urandom & scale;
      default: v = scale >> 1;
    endcase
    write_max_length(v);
    quiet = (phase % 4 == 3);
    // One phase runs against a receiver that stops taking results for a while.
    if (phase == 3) hold_off_req = 1'b1;
    if ($urandom_range(0, 9) != 0)
      send_request(make_item(KIND_CLEAR, $urandom, 4'($urandom)));
    r = $urandom_range(0, 99);
    if (r < 8) nb = 0;
    else if (r < 18) nb = TABLE_DEPTH + $urandom_range(0, 3);
    else nb = $urandom_range(1, 8);
    repeat (nb) begin
      r = $urandom_range(0, 19);
      v = (r == 0) ? '0 : (r == 1) ? '1 : $urandom & scale;
      send_request(make_item(KIND_ADD, v, 4'($urandom)));
    end
    repeat ($urandom_range(20, 60)) begin
      r = $urandom_range(0, 99);
      req = make_item(KIND_OBS, $urandom, 4'($urandom));
      if (r < 60) begin
        sub = $urandom_range(0, 9);
        if (sub < 4 && tracker.used > 0)
          req.value = tracker.bound_q[$urandom_range(0, tracker.used - 1)]
                      + $urandom_range(0, 2) - 1;
        else if (sub == 4)
          req.value = tracker.max_len + $urandom_range(0, 1);
        else if (sub == 5)
          req.value = $urandom_range(0, 1) ? '0 : '1;
        else
          req.value = $urandom & scale;
      end else if (r < 75) begin
        req.kind = KIND_READ;
        if ($urandom_range(0, 3) != 0 && tracker.used > 0)
          req.bucket_index = 4'($urandom_range(0, tracker.used - 1));
      end else if (r < 83) begin
        req.kind = KIND_TOTAL;
      end else if (r < 88) begin
        req.kind = KIND_ADD;
        req.value = $urandom & scale;
      end else if (r < 91) begin
        req.kind = KIND_CLEAR + 3'($urandom_range(1, 3));
      end else if (r < 93) begin
        req.kind = KIND_CLEAR;
      end else begin
        req.kind = 3'($urandom);
      end
      send_request(req);
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned s;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        s = pick_gap();
        if (s > 0) begin
          out_stall <= 1'b1;
          repeat (s) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall)
      tracker.compare_result(out_data);
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, equal bounds, extreme lengths and reads past the end.
    send_request(make_item(KIND_OBS, 32'd5, 4'd0));
    send_request(make_item(KIND_READ, 32'd0, 4'd0));
    send_request(make_item(KIND_ADD, 32'd100, 4'd0));
    send_request(make_item(KIND_ADD, 32'd10, 4'd0));
    send_request(make_item(KIND_ADD, 32'd100, 4'd0));
    send_request(make_item(KIND_ADD, 32'hFFFF_FFFF, 4'd0));
    send_request(make_item(KIND_ADD, 32'd0, 4'd0));
    send_request(make_item(KIND_OBS, 32'd9, 4'd0));
    send_request(make_item(KIND_OBS, 32'd10, 4'd0));
    send_request(make_item(KIND_OBS, 32'd100, 4'd0));
    send_request(make_item(KIND_OBS, 32'hFFFF_FFFF, 4'd0));
    send_request(make_item(KIND_READ, 32'd0, 4'd0));
    send_request(make_item(KIND_READ, 32'd0, 4'd2));
    send_request(make_item(KIND_READ, 32'd0, 4'd3));
    send_request(make_item(KIND_READ, 32'd0, 4'd15));
    send_request(make_item(3'd7, $urandom, 4'($urandom)));
    send_request(make_item(KIND_TOTAL, 32'd0, 4'd0));
    settle();
    write_max_length(32'd200);
    send_request(make_item(KIND_OBS, 32'd201, 4'd0));
    send_request(make_item(KIND_READ, 32'd0, 4'd3));
    send_request(make_item(KIND_CLEAR, 32'd0, 4'd0));
    send_request(make_item(KIND_TOTAL, 32'd0, 4'd0));

    phase = 0;
    while (items_sent < 1650) begin
      run_phase(phase);
      phase++;
    end

    in_valid <= 1'b0;
    waited = 0;
    while (tracker.pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (tracker.pending_results.size() != 0)
      tracker.report("results never delivered",
                     64'(tracker.pending_results.size()), '0);
    $display("sent %0d requests in %0d phases, %0d max_length writes, %0d results checked",
             items_sent, phase, cfg_writes, tracker.checked);
    $display("table-full results: %0d, no-bucket results: %0d, mismatches: %0d",
             tracker.full_seen, tracker.no_bucket_seen, tracker.errors);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
